@@ rtl/ympg_pkg.sv @@
// ----------------------------------------------------------------------------
// ympg_pkg
// Shared constants and codes of the yaw motion profile generator: register
// indexes, mode codes, fixed-point formats and sine series coefficients.
// ----------------------------------------------------------------------------
package ympg_pkg;

   // Fraction bits of every angle, rate and time value
   localparam int FRAC_BITS = 20;

   // Field widths
   localparam int TS_W   = 48;
   localparam int CFG_W  = 24;
   localparam int OUT_W  = 32;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 3;

   // Accumulator of the shared multiplier
   localparam int ACC_W  = 72;

   // Register indexes on the csr port
   localparam logic [IDX_W-1:0] CSR_MODE         = 3'd0;
   localparam logic [IDX_W-1:0] CSR_OFFSET_ANGLE = 3'd1;
   localparam logic [IDX_W-1:0] CSR_AMPLITUDE    = 3'd2;
   localparam logic [IDX_W-1:0] CSR_FREQUENCY    = 3'd3;
   localparam logic [IDX_W-1:0] CSR_ANGULAR_RATE = 3'd4;

   // Mode codes; the unused code behaves as fixed
   localparam logic [1:0] MODE_FIXED = 2'd0;
   localparam logic [1:0] MODE_SINE  = 2'd1;
   localparam logic [1:0] MODE_CONT  = 2'd2;

   // Reset value of the base angle: 0.65 rad
   localparam logic signed [CFG_W-1:0] OFFSET_RESET = 24'sd681574;

   // Milliseconds per second
   localparam logic [31:0] MS_PER_S = 32'd1000;

   // pi/2 in unsigned Q.30, and one in Q.30
   localparam logic [63:0] PIH_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // Largest magnitude kept by the rate product chain: 2^33
   localparam logic [34:0] RATE_CAP = 35'h200000000;

   // Taylor series of the sine table: term count and (2n)(2n+1) divisors
   localparam int SERIES_TERMS = 8;
   localparam int unsigned SERIES_DIV [SERIES_TERMS] =
      '{6, 20, 42, 72, 110, 156, 210, 272};

endpackage

@@ rtl/ympg_if.sv @@
// ----------------------------------------------------------------------------
// ympg request and response channels
// Valid/ready channels of the yaw motion profile generator: the tick
// request carrying a timestamp and the response carrying the profile sample.
// ----------------------------------------------------------------------------
interface ympg_req_if
   import ympg_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [TS_W-1:0] timestamp;

   modport source (output valid, output timestamp, input ready);
   modport sink   (input valid, input timestamp, output ready);
endinterface

interface ympg_rsp_if
   import ympg_pkg::*;
   ();
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] yaw_angle;
   logic signed [OUT_W-1:0] yaw_rate;
   logic [OUT_W-1:0]        sequence_number;
   logic [OUT_W-1:0]        elapsed_ms;

   modport source (output valid, output yaw_angle, output yaw_rate,
                   output sequence_number, output elapsed_ms, input ready);
   modport sink   (input valid, input yaw_angle, input yaw_rate,
                   input sequence_number, input elapsed_ms, output ready);
endinterface

@@ rtl/yaw_motion_profile_generator.sv @@
// Steps per tick: elapsed time and milliseconds in every mode, then the angle
// ramp in continuous mode, or phase, ROM reads and rate products in sine mode.
// A tick is taken only in idle, after the last result is loaded; a single 32x32 multiplier
// with a 72-bit accumulator works every product in turn, two passes per
// 48-bit or 35-bit operand. A result waiting on rsp stalls only the last step.
// Reset (synchronous): registers to defaults, start time and tick count to 0.
// ----------------------------------------------------------------------------
// yaw_motion_profile_generator
// Sine and ramp yaw test signal generator: per tick, elapsed time since the
// start time, yaw angle and rate for the selected mode, tick count and
// elapsed milliseconds. Sine and cosine come from a quarter-wave ROM.
// ----------------------------------------------------------------------------
module yaw_motion_profile_generator
   import ympg_pkg::*;
   #(
      parameter int TABLE_ADDR_BITS = 10
   )
   (
      input  logic             clock,
      input  logic             reset,
      ympg_req_if.sink         req_chan,
      ympg_rsp_if.source       rsp_chan,
      input  logic             csr_we,
      input  logic [IDX_W-1:0] csr_index,
      input  logic [CSR_W-1:0] csr_wdata
   );

   localparam int TBL_N   = 2 ** TABLE_ADDR_BITS;
   localparam int PHASE_W = TABLE_ADDR_BITS + 2;
   localparam logic [TABLE_ADDR_BITS:0] TBL_TOP = (TABLE_ADDR_BITS + 1)'(TBL_N);

   typedef logic [30:0] rom_type [TBL_N + 1];

   typedef enum logic [4:0] {
      S_IDLE, S_TIME, S_MS_LO, S_MS_HI, S_MS_WAIT, S_MS_TAKE,
      S_W_LO, S_W_HI, S_W_WAIT, S_W_TAKE,
      S_PH_LO, S_PH_HI, S_PH_WAIT, S_PH_TAKE,
      S_SIN_RD, S_COS_RD, S_M1_TAKE,
      S_M2_LO, S_M2_HI, S_M2_WAIT, S_M2_TAKE,
      S_M3_LO, S_M3_HI, S_M3_WAIT, S_M3_TAKE,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD_HI
   } acc_op_type;

   // Build the quarter-wave sine table in Q.30 by a floored Taylor series
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      longint      sum;
      for (int k = 0; k <= TBL_N; k++) begin
         x   = (PIH_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
         x2  = (x * x) >> 30;
         t   = x;
         sum = longint'(x);
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            t = ((t * x2) >> 30) / 64'(SERIES_DIV[n-1]);
            if (n[0]) begin
               sum = sum - longint'(t);
            end else begin
               sum = sum + longint'(t);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
         end
         rom[k] = 31'(sum);
      end
      return rom;
   endfunction

   localparam rom_type SIN_ROM = build_rom();

   // Clamp a wide signed value to 32 bits
   function automatic logic signed [OUT_W-1:0] sat_wide(input logic signed [53:0] v);
      if (v > 54'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -54'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[OUT_W-1:0];
      end
   endfunction

   // Apply a sign to a magnitude and clamp to 32 bits
   function automatic logic signed [OUT_W-1:0] sat_mag(input logic neg,
                                                        input logic [35:0] mag);
      if (!neg) begin
         return (mag > 36'h07fffffff) ? 32'sh7fffffff : signed'(mag[OUT_W-1:0]);
      end else begin
         return (mag > 36'h080000000) ? 32'sh80000000
                                      : signed'(32'd0 - mag[OUT_W-1:0]);
      end
   endfunction

   // Cap a Q.30 product quotient at 2^33
   function automatic logic [34:0] cap_q30(input logic [41:0] v);
      return (v > 42'(RATE_CAP)) ? RATE_CAP : v[34:0];
   endfunction

   // Configuration registers
   logic [1:0]              mode_ff;
   logic signed [CFG_W-1:0] offset_ff;
   logic signed [CFG_W-1:0] amplitude_ff;
   logic [31:0]             frequency_ff;
   logic signed [CFG_W-1:0] ang_rate_ff;

   // Sequencer and datapath registers
   state_type               state_ff;
   state_type               state_in;
   logic [TS_W-1:0]         ts_ff;
   logic [TS_W-1:0]         start_time_ff;
   logic [TS_W-1:0]         e_ff;
   logic [31:0]             tick_count_ff;
   logic [31:0]             ms_ff;
   logic signed [OUT_W-1:0] yaw_ff;
   logic signed [OUT_W-1:0] rate_ff;
   logic [PHASE_W-1:0]      idx_ff;
   logic [30:0]             smag_ff;
   logic [30:0]             cmag_ff;
   logic [34:0]             m_ff;
   logic [30:0]             rom_q_ff;
   logic [63:0]             prod_ff;
   acc_op_type              acc_op_ff;
   acc_op_type              acc_op_in;
   logic [ACC_W-1:0]        acc_ff;
   logic [ACC_W-1:0]        acc_in;

   // Response registers
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_yaw_ff;
   logic signed [OUT_W-1:0] rsp_rate_ff;
   logic [31:0]             rsp_seq_ff;
   logic [31:0]             rsp_ms_ff;

   // Shared multiplier operands and ROM address
   logic [31:0]             mul_a;
   logic [31:0]             mul_b;
   logic [TABLE_ADDR_BITS:0] rom_addr;

   // Operand magnitudes and signs
   logic                    amp_neg;
   logic [CFG_W-1:0]        amag;
   logic                    w_neg;
   logic [CFG_W-1:0]        wmag;
   logic [TABLE_ADDR_BITS-1:0] ph_addr;
   logic [1:0]              cos_quad;
   logic                    s_neg;
   logic                    c_neg;
   logic [TABLE_ADDR_BITS:0] sin_k;
   logic [TABLE_ADDR_BITS:0] cos_k;
   logic [ACC_W-FRAC_BITS-1:0] cont_mag;
   logic signed [53:0]      cont_sum;
   logic [24:0]             ys_mag;
   logic signed [OUT_W-1:0] ys_term;
   logic signed [OUT_W-1:0] off32;
   logic                    req_beat;
   logic                    rsp_beat;
   logic                    rsp_free;

   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.yaw_angle       = rsp_yaw_ff;
   assign rsp_chan.yaw_rate        = rsp_rate_ff;
   assign rsp_chan.sequence_number = rsp_seq_ff;
   assign rsp_chan.elapsed_ms      = rsp_ms_ff;

   // Magnitudes and signs of the signed registers
   assign amp_neg = amplitude_ff[CFG_W-1];
   assign amag    = amp_neg ? (CFG_W'(0) - amplitude_ff) : amplitude_ff;
   assign w_neg   = ang_rate_ff[CFG_W-1];
   assign wmag    = w_neg ? (CFG_W'(0) - ang_rate_ff) : ang_rate_ff;
   assign off32   = OUT_W'(offset_ff);

   // Fold the phase into a quarter-wave address; cosine is one quadrant on
   assign ph_addr  = idx_ff[TABLE_ADDR_BITS-1:0];
   assign cos_quad = idx_ff[PHASE_W-1:TABLE_ADDR_BITS] + 2'd1;
   assign s_neg    = idx_ff[PHASE_W-1];
   assign c_neg    = cos_quad[1];
   assign sin_k    = idx_ff[TABLE_ADDR_BITS] ? (TBL_TOP - {1'b0, ph_addr})
                                             : {1'b0, ph_addr};
   assign cos_k    = cos_quad[0] ? (TBL_TOP - {1'b0, ph_addr}) : {1'b0, ph_addr};
   assign rom_addr = (state_ff == S_SIN_RD) ? sin_k : cos_k;

   // Continuous ramp: offset plus or minus the scaled product
   assign cont_mag = acc_ff[ACC_W-1:FRAC_BITS];
   assign cont_sum = w_neg ? (54'(offset_ff) - signed'({2'b00, cont_mag}))
                           : (54'(offset_ff) + signed'({2'b00, cont_mag}));

   // Sine term of the angle
   assign ys_mag  = acc_ff[54:30];
   assign ys_term = (amp_neg ^ s_neg) ? signed'(32'd0 - 32'(ys_mag))
                                      : signed'(32'(ys_mag));

   // Hold the registers; index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_FIXED;
         offset_ff    <= OFFSET_RESET;
         amplitude_ff <= '0;
         frequency_ff <= '0;
         ang_rate_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:         mode_ff      <= csr_wdata[1:0];
            CSR_OFFSET_ANGLE: offset_ff    <= signed'(csr_wdata[CFG_W-1:0]);
            CSR_AMPLITUDE:    amplitude_ff <= signed'(csr_wdata[CFG_W-1:0]);
            CSR_FREQUENCY:    frequency_ff <= csr_wdata;
            CSR_ANGULAR_RATE: ang_rate_ff  <= signed'(csr_wdata[CFG_W-1:0]);
            default: ;
         endcase
      end
   end

   // Select multiplier operands and accumulate action per step
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      acc_op_in = ACC_HOLD;
      unique case (state_ff)
         S_MS_LO: begin
            mul_a = e_ff[31:0];               mul_b = MS_PER_S; acc_op_in = ACC_LOAD;
         end
         S_MS_HI: begin
            mul_a = 32'(e_ff[TS_W-1:32]);      mul_b = MS_PER_S; acc_op_in = ACC_ADD_HI;
         end
         S_W_LO: begin
            mul_a = e_ff[31:0];               mul_b = 32'(wmag); acc_op_in = ACC_LOAD;
         end
         S_W_HI: begin
            mul_a = 32'(e_ff[TS_W-1:32]);      mul_b = 32'(wmag); acc_op_in = ACC_ADD_HI;
         end
         S_PH_LO: begin
            mul_a = e_ff[31:0];               mul_b = frequency_ff; acc_op_in = ACC_LOAD;
         end
         S_PH_HI: begin
            mul_a = 32'(e_ff[TS_W-1:32]);      mul_b = frequency_ff; acc_op_in = ACC_ADD_HI;
         end
         S_SIN_RD: begin
            mul_a = frequency_ff;             mul_b = 32'(amag); acc_op_in = ACC_LOAD;
         end
         S_M1_TAKE: begin
            mul_a = 32'(smag_ff);             mul_b = 32'(amag); acc_op_in = ACC_LOAD;
         end
         S_M2_LO: begin
            mul_a = m_ff[31:0];               mul_b = 32'(cmag_ff); acc_op_in = ACC_LOAD;
         end
         S_M2_HI: begin
            mul_a = 32'(m_ff[34:32]);         mul_b = 32'(cmag_ff); acc_op_in = ACC_ADD_HI;
         end
         S_M3_LO: begin
            mul_a = m_ff[31:0];               mul_b = PIH_Q30[31:0]; acc_op_in = ACC_LOAD;
         end
         S_M3_HI: begin
            mul_a = 32'(m_ff[34:32]);         mul_b = PIH_Q30[31:0]; acc_op_in = ACC_ADD_HI;
         end
         default: ;
      endcase
   end

   // Fold the registered product into the accumulator
   always_comb begin
      unique case (acc_op_ff)
         ACC_LOAD:   acc_in = {8'b0, prod_ff};
         ACC_ADD_HI: acc_in = acc_ff + {prod_ff[ACC_W-33:0], 32'b0};
         default:    acc_in = acc_ff;
      endcase
   end

   // Shared multiplier with registered product, and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_op_ff <= ACC_HOLD;
      end else begin
         acc_op_ff <= acc_op_in;
      end
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      acc_ff  <= acc_in;
   end

   // Quarter-wave ROM with registered read data
   always_ff @(posedge clock) begin
      rom_q_ff <= SIN_ROM[rom_addr];
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_beat) state_in = S_TIME;
         S_TIME:    state_in = S_MS_LO;
         S_MS_LO:   state_in = S_MS_HI;
         S_MS_HI:   state_in = S_MS_WAIT;
         S_MS_WAIT: state_in = S_MS_TAKE;
         S_MS_TAKE: begin
            priority if (mode_ff == MODE_SINE) state_in = S_PH_LO;
            else if (mode_ff == MODE_CONT)     state_in = S_W_LO;
            else                               state_in = S_FIN;
         end
         S_W_LO:    state_in = S_W_HI;
         S_W_HI:    state_in = S_W_WAIT;
         S_W_WAIT:  state_in = S_W_TAKE;
         S_W_TAKE:  state_in = S_FIN;
         S_PH_LO:   state_in = S_PH_HI;
         S_PH_HI:   state_in = S_PH_WAIT;
         S_PH_WAIT: state_in = S_PH_TAKE;
         S_PH_TAKE: state_in = S_SIN_RD;
         S_SIN_RD:  state_in = S_COS_RD;
         S_COS_RD:  state_in = S_M1_TAKE;
         S_M1_TAKE: state_in = S_M2_LO;
         S_M2_LO:   state_in = S_M2_HI;
         S_M2_HI:   state_in = S_M2_WAIT;
         S_M2_WAIT: state_in = S_M2_TAKE;
         S_M2_TAKE: state_in = S_M3_LO;
         S_M3_LO:   state_in = S_M3_HI;
         S_M3_HI:   state_in = S_M3_WAIT;
         S_M3_WAIT: state_in = S_M3_TAKE;
         S_M3_TAKE: state_in = S_FIN;
         S_FIN:     if (rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // State, step results and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         start_time_ff <= '0;
         tick_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_beat) ts_ff <= req_chan.timestamp;
            end
            // Restart when time runs backwards
            S_TIME: begin
               if (ts_ff < start_time_ff) begin
                  start_time_ff <= ts_ff;
                  e_ff          <= '0;
               end else begin
                  e_ff <= ts_ff - start_time_ff;
               end
               yaw_ff  <= off32;
               rate_ff <= '0;
            end
            S_MS_TAKE: ms_ff   <= acc_ff[FRAC_BITS +: 32];
            S_W_TAKE: begin
               yaw_ff  <= sat_wide(cont_sum);
               rate_ff <= OUT_W'(ang_rate_ff);
            end
            S_PH_TAKE: idx_ff  <= acc_ff[2*FRAC_BITS-1 -: PHASE_W];
            S_COS_RD:  smag_ff <= rom_q_ff;
            S_M1_TAKE: begin
               cmag_ff <= rom_q_ff;
               m_ff    <= acc_ff[FRAC_BITS +: 35];
            end
            S_M2_HI:   yaw_ff  <= off32 + ys_term;
            S_M2_TAKE: m_ff    <= cap_q30(acc_ff[ACC_W-1:30]);
            S_M3_TAKE: rate_ff <= sat_mag(amp_neg ^ c_neg,
                                          36'({cap_q30(acc_ff[ACC_W-1:30]), 2'b00}));
            // Load the response once the previous beat is gone
            S_FIN: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_yaw_ff    <= yaw_ff;
                  rsp_rate_ff   <= rate_ff;
                  rsp_seq_ff    <= tick_count_ff;
                  rsp_ms_ff     <= ms_ff;
                  tick_count_ff <= tick_count_ff + 32'd1;
               end
            end
            default: ;
         endcase
         if (rsp_beat && !(state_ff == S_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // A tick beat makes the block busy on the next cycle
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_chan.ready)
      else $error("request taken while a tick is still in work");

   // A waiting response always carries the count just before the tick count
   a_seq_tracks_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (tick_count_ff == rsp_seq_ff + 32'd1))
      else $error("sequence number out of step with tick count");

   // Elapsed time is measured from a start time no later than the tick
   a_elapsed_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MS_LO) |-> ((start_time_ff <= ts_ff) &&
                                 (e_ff == ts_ff - start_time_ff)))
      else $error("elapsed time inconsistent with start time");

   // Fixed and unused modes give zero rate
   a_fixed_rate_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FIN) && (mode_ff != MODE_SINE) && (mode_ff != MODE_CONT))
      |-> (rate_ff == '0))
      else $error("nonzero rate in fixed mode");

endmodule

@@ tb/ympg_profile_checker.sv @@
// ----------------------------------------------------------------------------
// ympg_profile_checker
// Watches the tick, sample and csr ports of the yaw motion profile generator.
// Tracks the register file, start time and tick count, predicts the profile
// sample of every accepted tick and compares each returned sample with the
// oldest prediction. Hands the mismatch count and the number of samples
// still owed to the testbench top.
// ----------------------------------------------------------------------------
module ympg_profile_checker
   import ympg_pkg::*;
   #(
      parameter int TABLE_ADDR_BITS = 10
   )
   (
      input  logic             clock,
      input  logic             reset,
      ympg_req_if              tick_mon,
      ympg_rsp_if              sample_mon,
      input  logic             csr_we,
      input  logic [IDX_W-1:0] csr_index,
      input  logic [CSR_W-1:0] csr_wdata,
      output int               mismatch_count,
      output int               samples_owed
   );

   localparam int TBL_N       = 1 << TABLE_ADDR_BITS;
   localparam int Q30         = 30;
   localparam int PHASE_SHIFT = 2 * FRAC_BITS - TABLE_ADDR_BITS - 2;

   localparam longint unsigned PRODUCT_CAP = RATE_CAP;
   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct packed {
      logic signed [OUT_W-1:0] yaw_angle;
      logic signed [OUT_W-1:0] yaw_rate;
      logic [OUT_W-1:0]        sequence_number;
      logic [OUT_W-1:0]        elapsed_ms;
   } profile_sample_type;

   // Register file and profile state as the block should hold them
   logic [1:0]              mode_reg;
   logic signed [CFG_W-1:0] offset_reg;
   logic signed [CFG_W-1:0] amp_reg;
   logic [31:0]             freq_reg;
   logic signed [CFG_W-1:0] omega_reg;
   logic [TS_W-1:0]         start_time;
   logic [31:0]             tick_count;

   logic [31:0]        quarter_sine [0:TBL_N];
   profile_sample_type owed_samples [$];
   int                 failures;

   // Sine of x (unsigned Q.30) by Taylor series, terms floored, sum clamped
   function automatic logic [31:0] series_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      x2   = (x * x) >> Q30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= SERIES_TERMS; n++) begin
         term = ((term * x2) >> Q30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) acc = acc - longint'(term);
         else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > longint'(ONE_Q30)) acc = longint'(ONE_Q30);
      return acc[31:0];
   endfunction

   // Signed Q.30 sine of a quadrant-plus-address phase
   function automatic longint signed_sine(input logic [TABLE_ADDR_BITS+1:0] phase);
      logic [1:0]                 quad;
      logic [TABLE_ADDR_BITS-1:0] addr;
      int                         k;
      longint                     v;
      quad = phase[TABLE_ADDR_BITS+1 -: 2];
      addr = phase[TABLE_ADDR_BITS-1:0];
      k    = quad[0] ? TBL_N - int'(addr) : int'(addr);
      v    = longint'(quarter_sine[k]);
      return quad[1] ? -v : v;
   endfunction

   // floor(a * b / 2^30) worked in two halves of a, capped at 2^33
   function automatic longint unsigned scale_q30_capped(input longint unsigned a,
                                                        input longint unsigned b);
      longint unsigned hi;
      longint unsigned lo;
      longint unsigned r;
      if (b == 0) return 0;
      hi = a >> 32;
      lo = a & 64'hFFFF_FFFF;
      if (hi > (PRODUCT_CAP >> 2) / b) return PRODUCT_CAP;
      r = ((hi * b) << 2) + ((lo * b) >> Q30);
      return (r > PRODUCT_CAP) ? PRODUCT_CAP : r;
   endfunction

   function automatic logic [31:0] clamp_s32(input longint v);
      if (v > S32_MAX) return S32_MAX[31:0];
      if (v < S32_MIN) return S32_MIN[31:0];
      return v[31:0];
   endfunction

   // Work out the sample of one tick and advance start time and tick count
   function automatic profile_sample_type predict_sample(input logic [TS_W-1:0] ts);
      logic [TS_W-1:0]            span;
      logic [79:0]                turns_full;
      logic [TABLE_ADDR_BITS+1:0] phase;
      logic [63:0]                ms;
      longint                     off, yaw, rate, amp, w, s, c;
      longint unsigned            amag, smag, cmag, ys, mag, wmag, pm;
      profile_sample_type         smp;

      if (ts < start_time) begin
         start_time = ts;
         span       = '0;
      end else begin
         span = ts - start_time;
      end

      off  = longint'(offset_reg);
      yaw  = off;
      rate = 0;
      unique case (mode_reg)
         MODE_SINE: begin
            amp        = longint'(amp_reg);
            amag       = (amp < 0) ? -amp : amp;
            turns_full = freq_reg * span;
            phase      = turns_full[PHASE_SHIFT +: TABLE_ADDR_BITS+2];
            s          = signed_sine(phase);
            c          = signed_sine(phase + (TABLE_ADDR_BITS+2)'(TBL_N));
            smag       = (s < 0) ? -s : s;
            cmag       = (c < 0) ? -c : c;
            ys         = (amag * smag) >> Q30;
            yaw        = off + (((amp < 0) != (s < 0)) ? -longint'(ys) : longint'(ys));
            // rate chain: f*|A|, then |cos|, then pi/2, floored each step, the last two capped
            mag  = (longint'(freq_reg) * amag) >> FRAC_BITS;
            mag  = scale_q30_capped(mag, cmag);
            mag  = scale_q30_capped(mag, PIH_Q30);
            mag  = mag << 2;
            rate = ((amp < 0) != (c < 0)) ? -longint'(mag) : longint'(mag);
         end
         MODE_CONT: begin
            w    = longint'(omega_reg);
            wmag = (w < 0) ? -w : w;
            if (wmag != 0 && span > (64'd1 << 62) / wmag) pm = (64'd1 << 62) >> FRAC_BITS;
            else                                           pm = (wmag * span) >> FRAC_BITS;
            yaw  = (w < 0) ? off - longint'(pm) : off + longint'(pm);
            rate = w;
         end
         default: ;
      endcase

      ms                  = (longint'(span) * MS_PER_S) >> FRAC_BITS;
      smp.yaw_angle       = clamp_s32(yaw);
      smp.yaw_rate        = clamp_s32(rate);
      smp.sequence_number = tick_count;
      smp.elapsed_ms      = ms[31:0];
      tick_count          = tick_count + 1;
      return smp;
   endfunction

   task automatic check_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         failures++;
      end
   endtask

   // Build the quarter-wave sine table once
   initial begin : build_quarter_sine
      for (int k = 0; k <= TBL_N; k++) begin
         quarter_sine[k] = series_sine((PIH_Q30 * longint'(k)) >> TABLE_ADDR_BITS);
      end
   end

   // Track registers, predict on every tick beat, compare on every sample beat
   always @(posedge clock) begin : watch_channels
      profile_sample_type want;
      if (reset) begin
         mode_reg   = MODE_FIXED;
         offset_reg = OFFSET_RESET;
         amp_reg    = '0;
         freq_reg   = '0;
         omega_reg  = '0;
         start_time = '0;
         tick_count = '0;
         failures   = 0;
         owed_samples.delete();
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MODE:         mode_reg   = csr_wdata[1:0];
               CSR_OFFSET_ANGLE: offset_reg = csr_wdata[CFG_W-1:0];
               CSR_AMPLITUDE:    amp_reg    = csr_wdata[CFG_W-1:0];
               CSR_FREQUENCY:    freq_reg   = csr_wdata[31:0];
               CSR_ANGULAR_RATE: omega_reg  = csr_wdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (sample_mon.valid && sample_mon.ready) begin
            if (owed_samples.size() == 0) begin
               $error("profile sample beat with no tick outstanding");
               failures++;
            end else begin
               want = owed_samples.pop_front();
               check_field("yaw_angle", $signed(want.yaw_angle),
                           $signed(sample_mon.yaw_angle));
               check_field("yaw_rate", $signed(want.yaw_rate),
                           $signed(sample_mon.yaw_rate));
               check_field("sequence_number", want.sequence_number,
                           sample_mon.sequence_number);
               check_field("elapsed_ms", want.elapsed_ms, sample_mon.elapsed_ms);
            end
         end
         if (tick_mon.valid && tick_mon.ready) begin
            owed_samples.push_back(predict_sample(tick_mon.timestamp));
         end
      end
      mismatch_count <= failures;
      samples_owed   <= owed_samples.size();
   end

endmodule

@@ tb/yaw_motion_profile_generator_tb.sv @@
// ----------------------------------------------------------------------------
// yaw_motion_profile_generator_tb
// Drives ticks and register writes into the yaw motion profile generator:
// a directed pass over register extremes, every mode, time going backwards
// and zero frequency, then phases of random profiles with mostly forward
// timestamps. Both channels idle at random; the sample side once holds off
// long enough to back the block up. The checker beside the block predicts
// and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module yaw_motion_profile_generator_tb;
   import ympg_pkg::*;

   localparam int TABLE_ADDR_BITS = 10;
   localparam int RESET_CYCLES    = 12;
   localparam int RANDOM_TICKS    = 1430;
   localparam int LONG_HOLD       = 400;
   localparam int SETTLE_CYCLES   = 40;
   // About 1450 ticks in the slowest mode with the largest gaps on both
   // sides, plus the long hold, taken several times over
   localparam int CYCLE_LIMIT     = 600000;

   // Codes beyond the documented ones
   localparam logic [1:0]       MODE_SPARE = 2'd3;
   localparam logic [IDX_W-1:0] CSR_SPARE  = CSR_ANGULAR_RATE + 3'd1;

   localparam logic signed [CFG_W-1:0] Q3_MAX = 24'sh7FFFFF;
   localparam logic signed [CFG_W-1:0] Q3_MIN = 24'sh800000;
   localparam logic [TS_W-1:0]         TS_MAX = '1;
   localparam logic [TS_W-1:0]         ONE_S  = 48'd1 << FRAC_BITS;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;
   int               mismatch_count;
   int               samples_owed;
   int               cycle_count   = 0;
   int               req_gap_max   = 18;
   int               rsp_gap_max   = 18;
   bit               rsp_long_hold = 1'b0;
   logic [TS_W-1:0]  tick_clock    = '0;

   ympg_req_if tick_chan();
   ympg_rsp_if sample_chan();

   yaw_motion_profile_generator #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (tick_chan),
      .rsp_chan  (sample_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ympg_profile_checker #(.TABLE_ADDR_BITS(TABLE_ADDR_BITS)) profile_check (
      .clock          (clock),
      .reset          (reset),
      .tick_mon       (tick_chan),
      .sample_mon     (sample_chan),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .samples_owed   (samples_owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Offer one tick after a random gap and hold it until the beat
   task automatic send_tick(input logic [TS_W-1:0] ts);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         tick_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      tick_chan.valid     <= 1'b1;
      tick_chan.timestamp <= ts;
      do @(posedge clock); while (!tick_chan.ready);
   endtask

   // Drop valid and wait until every owed sample has come back
   task automatic hold_until_drained();
      tick_chan.valid <= 1'b0;
      do @(posedge clock); while (samples_owed != 0);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Load a whole profile once idle; junk rides in the bits above each field narrower than the word
   task automatic apply_profile(input logic [1:0] mode, input logic signed [CFG_W-1:0] off,
                                input logic signed [CFG_W-1:0] amp, input logic [31:0] freq,
                                input logic signed [CFG_W-1:0] omega);
      logic [31:0] junk;
      hold_until_drained();
      junk = $urandom;
      csr_write(CSR_MODE, {junk[31:2], mode});
      csr_write(CSR_OFFSET_ANGLE, {junk[31:24], off});
      csr_write(CSR_AMPLITUDE, {junk[7:0], amp});
      csr_write(CSR_FREQUENCY, freq);
      csr_write(CSR_ANGULAR_RATE, {junk[15:8], omega});
      csr_write(CSR_SPARE + IDX_W'($urandom_range(0, 2)), $urandom);
   endtask

   function automatic logic signed [CFG_W-1:0] pick_q3();
      case ($urandom_range(0, 6))
         0:       return Q3_MAX;
         1:       return Q3_MIN;
         2:       return '0;
         3, 4:    return CFG_W'($urandom_range(0, 4194303) - 2097152);
         default: return CFG_W'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_hz();
      case ($urandom_range(0, 7))
         0:       return '1;
         1:       return '0;
         2, 3:    return $urandom;
         default: return $urandom_range(0, 1 << 25);
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return MODE_SINE;
         4, 5, 6:    return MODE_CONT;
         7, 8:       return MODE_FIXED;
         default:    return MODE_SPARE;
      endcase
   endfunction

   function automatic int pick_gap_limit();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 4;
         default: return 18;
      endcase
   endfunction

   // Mostly forward steps at tick rate; now and then a jump, a step back or noise
   function automatic logic [TS_W-1:0] next_timestamp();
      logic [63:0] wide;
      int          roll;
      wide = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 80)      tick_clock = tick_clock + $urandom_range(0, 1 << 17);
      else if (roll < 88) tick_clock = tick_clock + $urandom;
      else if (roll < 94) tick_clock = tick_clock - $urandom_range(1, 1 << 20);
      else                tick_clock = wide[TS_W-1:0];
      return tick_clock;
   endfunction

   // Sample side: random hold per beat, one long hold on request
   initial begin : sample_sink
      int hold;
      bit long_hold_taken;
      long_hold_taken = 1'b0;
      sample_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_long_hold && !long_hold_taken) begin
            hold            = LONG_HOLD;
            long_hold_taken = 1'b1;
         end else begin
            hold = $urandom_range(0, rsp_gap_max);
         end
         if (hold > 0) begin
            sample_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         sample_chan.ready <= 1'b1;
         do @(posedge clock); while (!sample_chan.valid);
      end
   end

   initial begin : tick_source
      int issued;
      int phase_no;
      int span_ticks;
      tick_chan.valid     <= 1'b0;
      tick_chan.timestamp <= '0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_MODE;
      csr_wdata           <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset profile: fixed at the base angle; then time going backwards
      send_tick('0);
      send_tick(TS_MAX);
      send_tick(48'd5);

      // Unused mode behaves as fixed
      apply_profile(MODE_SPARE, Q3_MIN, Q3_MAX, '1, Q3_MAX);
      send_tick(48'd5 + ONE_S);

      // Continuous rotation into both saturation rails
      apply_profile(MODE_CONT, Q3_MAX, '0, '0, Q3_MAX);
      send_tick(TS_MAX);
      send_tick(48'd1 << 40);
      apply_profile(MODE_CONT, Q3_MIN, '0, '0, Q3_MIN);
      send_tick(TS_MAX);
      send_tick('0);
      send_tick(ONE_S);

      // Sine at the largest amplitude and frequency: rate chain caps
      apply_profile(MODE_SINE, '0, Q3_MAX, '1, '0);
      send_tick('0);
      send_tick(48'd1);
      send_tick(TS_MAX);
      send_tick(48'h0001_2345_6789);

      // 1 Hz sine sampled on quadrant boundaries
      apply_profile(MODE_SINE, Q3_MAX, Q3_MIN, 32'd1 << FRAC_BITS, '0);
      send_tick(ONE_S >> 2);
      send_tick(ONE_S >> 1);
      send_tick((ONE_S >> 2) * 3);

      // Zero frequency leaves only the offset
      apply_profile(MODE_SINE, Q3_MIN, Q3_MIN, '0, Q3_MAX);
      send_tick(TS_MAX);

      // Random profiles, each a burst of ticks
      issued   = 0;
      phase_no = 0;
      while (issued < RANDOM_TICKS) begin
         apply_profile(pick_mode(), pick_q3(), pick_q3(), pick_hz(), pick_q3());
         req_gap_max = pick_gap_limit();
         rsp_gap_max = pick_gap_limit();
         if (phase_no == 2) begin
            // back the block up behind a stalled sample side
            rsp_long_hold = 1'b1;
            req_gap_max   = 0;
         end
         span_ticks = $urandom_range(20, 60);
         repeat (span_ticks) send_tick(next_timestamp());
         issued   += span_ticks;
         phase_no += 1;
      end

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("ALL CHECKS PASSED");
      else                     $display("CHECKS FAILED");
      $finish;
   end

endmodule
